>>> rtl/core/lmrs_pkg.sv
// Shared types and constants for the LED matrix row-scan shifter.
package lmrs_pkg;

    localparam int FRAME_ROWS   = 16;
    localparam int MATRIX_WIDTH = 8;
    localparam int ROW_W        = $clog2(MATRIX_WIDTH);
    localparam int IDX_W        = $clog2(FRAME_ROWS);
    localparam int CHAIN_BYTES  = 4;
    localparam int CHAIN_BITS   = CHAIN_BYTES * MATRIX_WIDTH;
    localparam int CNT_W        = $clog2(CHAIN_BITS);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_BLANK = 2'd2;

    localparam logic [MATRIX_WIDTH-1:0] BYTE_OFF = '0;
    localparam logic [MATRIX_WIDTH-1:0] BYTE_ON  = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

>>> rtl/core/lmrs_if.sv
// Handshake interfaces for the input and result channels of the row-scan shifter.
interface lmrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] row_index;
    logic [7:0] pixel_row;

    modport source (output valid, output mode, output row_index, output pixel_row,
                    input ready);
    modport sink   (input valid, input mode, input row_index, input pixel_row,
                    output ready);
endinterface

interface lmrs_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch_after;

    modport source (output valid, output serial_bit, output latch_after, input ready);
    modport sink   (input valid, input serial_bit, input latch_after, output ready);
endinterface

>>> rtl/core/lmrs_cell.sv
// One bit cell of the serial output chain: parallel load or shift from its neighbor.
module lmrs_cell (
    input  logic                i_clk,
    input  lmrs_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_load_bit,
    input  logic                i_prev_bit,
    output logic                o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.load) begin
            n_bit = i_load_bit;
        end else if (i_ctrl.shift) begin
            n_bit = i_prev_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

>>> rtl/core/lmrs_frame_store.sv
// Frame store of row bytes, organized as upper and lower halves per physical row.
module lmrs_frame_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [lmrs_pkg::IDX_W-1:0]          i_wr_idx,
    input  logic [lmrs_pkg::MATRIX_WIDTH-1:0]   i_wr_data,
    input  logic [lmrs_pkg::ROW_W-1:0]          i_rd_row,
    output logic [lmrs_pkg::MATRIX_WIDTH-1:0]   o_upper,
    output logic [lmrs_pkg::MATRIX_WIDTH-1:0]   o_lower
);

    localparam int W = lmrs_pkg::MATRIX_WIDTH;

    logic [2*W-1:0]                      r_mem [lmrs_pkg::MATRIX_WIDTH];
    logic [lmrs_pkg::FRAME_ROWS-1:0]     r_valid;
    logic [2*W-1:0]                      r_rd_data;
    logic [1:0]                          r_rd_vld;
    logic                                w_half;
    logic [lmrs_pkg::ROW_W-1:0]          w_row;

    assign w_half = i_wr_idx[lmrs_pkg::IDX_W-1];
    assign w_row  = i_wr_idx[lmrs_pkg::ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (w_half) begin
                r_mem[w_row][2*W-1:W] <= i_wr_data;
            end else begin
                r_mem[w_row][W-1:0] <= i_wr_data;
            end
        end
        r_rd_data <= r_mem[i_rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= '0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            r_rd_vld <= {r_valid[{1'b1, i_rd_row}], r_valid[{1'b0, i_rd_row}]};
        end
    end

    assign o_upper = r_rd_vld[0] ? r_rd_data[W-1:0]   : lmrs_pkg::BYTE_OFF;
    assign o_lower = r_rd_vld[1] ? r_rd_data[2*W-1:W] : lmrs_pkg::BYTE_OFF;

endmodule

>>> rtl/core/led_matrix_row_scan_shifter.sv
// Top level of the LED matrix row-scan shifter for two stacked 8x8 matrices.
//
// Input channel i_in carries one command per transaction: mode 0 writes
// pixel_row into frame row row_index, mode 1 scans the next physical row,
// mode 2 blanks both matrices, and mode 3 is dropped without effect.
// A write produces no result.
// Scan and blank produce 32 result transactions on o_out, one serial bit
// each, MSB first: lower-matrix columns, row select, upper-matrix columns,
// row select. latch_after is high on the 32nd bit only.
// A scan or blank is accepted in ST_IDLE; ST_LOAD then does the parallel load
// of the 32-cell chain from the registered frame-store read, and ST_SHIFT
// shifts out one bit of the chain per accepted result transaction.
// A new command is accepted only after the 32nd bit has been taken.
// When the receiver holds ready low, the chain holds its bits and the
// current bit stays on o_out; nothing is lost.
// Reset clears the frame store to all zeros (by valid bits), the row
// counter to zero, and returns the block to idle with no result pending.
module led_matrix_row_scan_shifter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lmrs_in_if.sink         i_in,
    lmrs_out_if.source      o_out
);

    localparam int NB = lmrs_pkg::CHAIN_BITS;

    lmrs_pkg::t_state                     r_state;
    lmrs_pkg::t_state                     n_state;
    logic [lmrs_pkg::CNT_W-1:0]           r_cnt;
    logic [lmrs_pkg::CNT_W-1:0]           n_cnt;
    logic                                 r_is_scan;
    logic                                 n_is_scan;
    logic [lmrs_pkg::ROW_W-1:0]           r_scan_row;
    logic [lmrs_pkg::ROW_W-1:0]           n_scan_row;

    logic                                 w_in_acc;
    logic                                 w_out_acc;
    logic                                 w_last;
    logic                                 w_wr_en;
    lmrs_pkg::t_cell_ctrl                 w_ctrl;
    logic [lmrs_pkg::MATRIX_WIDTH-1:0]    w_upper;
    logic [lmrs_pkg::MATRIX_WIDTH-1:0]    w_lower;
    logic [lmrs_pkg::MATRIX_WIDTH-1:0]    w_sel;
    logic [NB-1:0]                        w_load_vec;
    logic [NB-1:0]                        w_chain;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_last    = (r_cnt == lmrs_pkg::CNT_W'(NB - 1));
    assign w_wr_en   = w_in_acc && (i_in.mode == lmrs_pkg::MODE_WRITE);

    lmrs_frame_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (i_in.row_index),
        .i_wr_data (i_in.pixel_row),
        .i_rd_row  (r_scan_row),
        .o_upper   (w_upper),
        .o_lower   (w_lower)
    );

    assign w_sel = ~(lmrs_pkg::MATRIX_WIDTH'(1) << r_scan_row);

    always_comb begin
        if (r_is_scan) begin
            w_load_vec = {w_lower, w_sel, w_upper, w_sel};
        end else begin
            w_load_vec = {lmrs_pkg::BYTE_OFF, lmrs_pkg::BYTE_ON,
                          lmrs_pkg::BYTE_OFF, lmrs_pkg::BYTE_ON};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_is_scan   = r_is_scan;
        n_scan_row  = r_scan_row;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        w_ctrl      = '0;
        case (r_state)
            lmrs_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    case (i_in.mode)
                        lmrs_pkg::MODE_SCAN: begin
                            n_state   = lmrs_pkg::ST_LOAD;
                            n_is_scan = 1'b1;
                        end
                        lmrs_pkg::MODE_BLANK: begin
                            n_state   = lmrs_pkg::ST_LOAD;
                            n_is_scan = 1'b0;
                        end
                        default: begin
                            n_state = lmrs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lmrs_pkg::ST_LOAD: begin
                w_ctrl.load = 1'b1;
                n_cnt       = '0;
                n_state     = lmrs_pkg::ST_SHIFT;
                if (r_is_scan) begin
                    n_scan_row = r_scan_row + lmrs_pkg::ROW_W'(1);
                end
            end
            lmrs_pkg::ST_SHIFT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    w_ctrl.shift = 1'b1;
                    n_cnt        = r_cnt + lmrs_pkg::CNT_W'(1);
                    if (w_last) begin
                        n_state = lmrs_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lmrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lmrs_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_is_scan  <= 1'b0;
            r_scan_row <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_is_scan  <= n_is_scan;
            r_scan_row <= n_scan_row;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NB; k++) begin : g_cell
            if (k == 0) begin : g_tail
                lmrs_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_load_bit (w_load_vec[k]),
                    .i_prev_bit (1'b0),
                    .o_bit      (w_chain[k])
                );
            end else begin : g_body
                lmrs_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_load_bit (w_load_vec[k]),
                    .i_prev_bit (w_chain[k-1]),
                    .o_bit      (w_chain[k])
                );
            end
        end
    endgenerate

    assign o_out.serial_bit  = w_chain[NB-1];
    assign o_out.latch_after = w_last;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input accepted while a result is pending");

    a_scan_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.mode == lmrs_pkg::MODE_SCAN || i_in.mode == lmrs_pkg::MODE_BLANK))
        |=> r_state == lmrs_pkg::ST_LOAD)
        else $error("scan or blank transaction did not start a chain load");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.latch_after) |=> r_state == lmrs_pkg::ST_IDLE)
        else $error("block did not return to idle after the latch bit");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmrs_pkg::ST_LOAD && r_is_scan)
        |=> r_scan_row == lmrs_pkg::ROW_W'($past(r_scan_row) + lmrs_pkg::ROW_W'(1)))
        else $error("row counter did not advance after a scan");

    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lmrs_pkg::ST_LOAD) |=> $stable(r_scan_row))
        else $error("row counter changed outside a scan load");
`endif

endmodule

>>> bench/tb_led_matrix_row_scan_shifter.sv
// Self-checking testbench for the LED matrix row-scan shifter: directed table, then random commands.
module tb_led_matrix_row_scan_shifter;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 20;
    localparam int N_DIRECTED     = 22;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  row_index;
        logic [7:0]  pixel_row;
        logic        typed;
        logic [31:0] chain_word;
    } t_cmd_row;

    typedef struct packed {
        logic serial_bit;
        logic latch_after;
    } t_chain_bit;

    localparam t_cmd_row DIRECTED [N_DIRECTED] = '{
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b1, 32'h00FE00FE},
        '{lmrs_pkg::MODE_BLANK,  4'h0, 8'h00, 1'b1, 32'h00FF00FF},
        '{MODE_UNUSED,           4'hF, 8'hFF, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_WRITE,  4'h0, 8'hFF, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_WRITE,  4'h8, 8'h81, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_WRITE,  4'hF, 8'hFF, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_WRITE,  4'h7, 8'h01, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'hF, 8'hFF, 1'b1, 32'h00FD00FD},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b1, 32'hFF7F017F},
        '{MODE_UNUSED,           4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b1, 32'h81FEFFFE},
        '{lmrs_pkg::MODE_BLANK,  4'hA, 8'h5A, 1'b1, 32'h00FF00FF},
        '{lmrs_pkg::MODE_WRITE,  4'h3, 8'h55, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_WRITE,  4'hB, 8'hAA, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b0, 32'h0},
        '{lmrs_pkg::MODE_SCAN,   4'h0, 8'h00, 1'b1, 32'hAAF755F7}
    };

    logic i_clk;
    logic i_rst_n;

    lmrs_in_if  in_if ();
    lmrs_out_if out_if ();

    led_matrix_row_scan_shifter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [7:0]                 pixel_store [lmrs_pkg::FRAME_ROWS];
    logic [lmrs_pkg::ROW_W-1:0] next_row;
    t_chain_bit                 pending_bits [$];

    int gap_pct;
    int stall_pct;
    int errors;
    int bits_checked;
    int n_writes;
    int n_scans;
    int n_blanks;
    int n_ignored;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic push_chain_word(input logic [31:0] word);
        t_chain_bit b;
        for (int i = 31; i >= 0; i--) begin
            b.serial_bit  = word[i];
            b.latch_after = (i == 0);
            pending_bits.push_back(b);
        end
    endtask

    task automatic predict_command(input logic [1:0] m, input logic [3:0] ix,
                                   input logic [7:0] px, input logic typed,
                                   input logic [31:0] typed_word);
        logic [31:0] word;
        logic [7:0]  sel;
        word = '0;
        case (m)
            lmrs_pkg::MODE_WRITE: begin
                pixel_store[ix] = px;
                n_writes++;
            end
            lmrs_pkg::MODE_SCAN: begin
                sel  = ~(8'd1 << next_row);
                word = {pixel_store[{1'b1, next_row}], sel, pixel_store[{1'b0, next_row}], sel};
                next_row = next_row + 1'b1;
                n_scans++;
            end
            lmrs_pkg::MODE_BLANK: begin
                word = {lmrs_pkg::BYTE_OFF, lmrs_pkg::BYTE_ON,
                        lmrs_pkg::BYTE_OFF, lmrs_pkg::BYTE_ON};
                n_blanks++;
            end
            default: begin
                n_ignored++;
            end
        endcase
        if (m == lmrs_pkg::MODE_SCAN || m == lmrs_pkg::MODE_BLANK) begin
            push_chain_word(typed ? typed_word : word);
        end
    endtask

    task automatic send_command(input logic [1:0] m, input logic [3:0] ix,
                                input logic [7:0] px, input logic typed,
                                input logic [31:0] typed_word);
        in_if.valid     <= 1'b1;
        in_if.mode      <= m;
        in_if.row_index <= ix;
        in_if.pixel_row <= px;
        do begin
            @(posedge i_clk);
        end while (!(in_if.valid && in_if.ready));
        predict_command(m, ix, px, typed, typed_word);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            in_if.valid <= 1'b0;
            while ($urandom_range(99) < gap_pct) begin
                @(posedge i_clk);
            end
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_chain_bit exp_bit;
        out_if.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_bits.size() == 0) begin
                $display("%0t: unexpected result transaction, serial_bit %b latch_after %b",
                         $time, out_if.serial_bit, out_if.latch_after);
                errors++;
            end else begin
                exp_bit = pending_bits.pop_front();
                bits_checked++;
                if (out_if.serial_bit !== exp_bit.serial_bit) begin
                    $display("%0t: serial_bit mismatch, expected %b actual %b",
                             $time, exp_bit.serial_bit, out_if.serial_bit);
                    errors++;
                end
                if (out_if.latch_after !== exp_bit.latch_after) begin
                    $display("%0t: latch_after mismatch, expected %b actual %b",
                             $time, exp_bit.latch_after, out_if.latch_after);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_bits.size());
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [1:0] m;
        logic [3:0] ix;
        logic [7:0] px;
        int         pick;
        int         counted;

        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.mode      <= lmrs_pkg::MODE_WRITE;
        in_if.row_index <= '0;
        in_if.pixel_row <= '0;
        gap_pct      = 0;
        stall_pct    = 0;
        n_writes     = 0;
        n_scans      = 0;
        n_blanks     = 0;
        n_ignored    = 0;
        next_row     = '0;
        for (int i = 0; i < lmrs_pkg::FRAME_ROWS; i++) begin
            pixel_store[i] = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_command(DIRECTED[i].mode, DIRECTED[i].row_index, DIRECTED[i].pixel_row,
                         DIRECTED[i].typed, DIRECTED[i].chain_word);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 77; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 77; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                ix   = $urandom_range(15);
                px   = $urandom_range(255);
                if ($urandom_range(9) == 0) begin
                    px = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                if (pick < 38) begin
                    m = lmrs_pkg::MODE_WRITE;
                end else if (pick < 75) begin
                    m = lmrs_pkg::MODE_SCAN;
                end else if (pick < 92) begin
                    m = lmrs_pkg::MODE_BLANK;
                end else begin
                    m = MODE_UNUSED;
                end
                send_command(m, ix, px, 1'b0, 32'h0);
                if (m != MODE_UNUSED) begin
                    counted++;
                end
            end
        end

        in_if.valid <= 1'b0;
        while (pending_bits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d writes, %0d scans, %0d blanks and %0d ignored commands,",
                 n_writes, n_scans, n_blanks, n_ignored);
        $display("with %0d serial bits checked under four idle and stall mixes.", bits_checked);
        if (errors == 0 && pending_bits.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lmrs_pkg.sv
rtl/core/lmrs_if.sv
rtl/core/lmrs_cell.sv
rtl/core/lmrs_frame_store.sv
rtl/core/led_matrix_row_scan_shifter.sv
bench/tb_led_matrix_row_scan_shifter.sv
